// ===== rtl/deq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and codes for the double-ended queue: request codes, status
// codes, controller states and the command bundle from controller to datapath.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_REAR  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_REAR   = 3'd3,
        OP_PEEK_FRONT = 3'd4,
        OP_PEEK_REAR  = 3'd5
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // latch the incoming request word
        logic exec;      // evaluate the request, touch the RAM and pointers
        logic respond;   // present the result word for one cycle
    } t_cmd;

endpackage
`default_nettype wire

// ===== rtl/deq_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// deq_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/deq_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// deq_ctrl
// Request sequencer: capture, execute, respond.
// ----------------------------------------------------------------------------
module deq_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    output deq_pkg::t_cmd      o_cmd
);

    deq_pkg::t_state r_state;
    deq_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= deq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // A new request may be taken in the respond cycle as well as when idle.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            deq_pkg::S_IDLE: begin
                if (i_start) n_state = deq_pkg::S_EXEC;
            end
            deq_pkg::S_EXEC: begin
                n_state = deq_pkg::S_RESP;
            end
            deq_pkg::S_RESP: begin
                n_state = i_start ? deq_pkg::S_EXEC : deq_pkg::S_IDLE;
            end
            default: begin
                n_state = deq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            deq_pkg::S_IDLE: begin
                o_cmd.capture = i_start;
            end
            deq_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            deq_pkg::S_RESP: begin
                o_cmd.capture = i_start;
                o_cmd.respond = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/deq_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// deq_dp
// Datapath: request register, ring pointers, element count, slot RAM and
// result registers.
// ----------------------------------------------------------------------------
module deq_dp #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  deq_pkg::t_cmd                   i_cmd,
    input  wire logic [deq_pkg::OP_W-1:0]   i_operation,
    input  wire logic [WIDTH-1:0]           i_push_value,
    output logic      [WIDTH-1:0]           o_read_value,
    output logic      [deq_pkg::STATUS_W-1:0] o_status,
    output logic      [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    deq_pkg::t_op     r_op;
    logic [WIDTH-1:0] r_val;

    logic [AW-1:0]    r_head, n_head;
    logic [AW-1:0]    r_tail, n_tail;
    logic [CNT_W-1:0] r_cnt,  n_cnt;
    deq_pkg::t_status r_status, n_status;
    logic             r_rd_ok, n_rd_ok;

    logic [AW-1:0]    head_next, head_prev, tail_next, tail_prev;
    logic             full, empty;
    logic             ram_we, ram_re;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    logic [WIDTH-1:0] ram_rdata;

    assign full      = (r_cnt == CNT_W'(DEPTH));
    assign empty     = (r_cnt == '0);
    assign head_next = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);
    assign head_prev = (r_head == '0) ? AW'(DEPTH - 1) : r_head - AW'(1);
    assign tail_next = (r_tail == AW'(DEPTH - 1)) ? '0 : r_tail + AW'(1);
    assign tail_prev = (r_tail == '0) ? AW'(DEPTH - 1) : r_tail - AW'(1);

    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_cnt     = r_cnt;
        n_status  = deq_pkg::ST_OK;
        n_rd_ok   = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = r_tail;
        ram_raddr = r_head;
        unique case (r_op)
            deq_pkg::OP_PUSH_FRONT: begin
                if (full) begin
                    n_status = deq_pkg::ST_FULL;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = head_prev;
                    n_head    = head_prev;
                    n_cnt     = r_cnt + CNT_W'(1);
                end
            end
            deq_pkg::OP_PUSH_REAR: begin
                if (full) begin
                    n_status = deq_pkg::ST_FULL;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = r_tail;
                    n_tail    = tail_next;
                    n_cnt     = r_cnt + CNT_W'(1);
                end
            end
            deq_pkg::OP_POP_FRONT: begin
                if (empty) begin
                    n_status = deq_pkg::ST_EMPTY;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = r_head;
                    n_rd_ok   = 1'b1;
                    n_head    = head_next;
                    n_cnt     = r_cnt - CNT_W'(1);
                end
            end
            deq_pkg::OP_POP_REAR: begin
                if (empty) begin
                    n_status = deq_pkg::ST_EMPTY;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = tail_prev;
                    n_rd_ok   = 1'b1;
                    n_tail    = tail_prev;
                    n_cnt     = r_cnt - CNT_W'(1);
                end
            end
            deq_pkg::OP_PEEK_FRONT: begin
                if (empty) begin
                    n_status = deq_pkg::ST_EMPTY;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = r_head;
                    n_rd_ok   = 1'b1;
                end
            end
            deq_pkg::OP_PEEK_REAR: begin
                if (empty) begin
                    n_status = deq_pkg::ST_EMPTY;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = tail_prev;
                    n_rd_ok   = 1'b1;
                end
            end
            default: begin
                n_status = deq_pkg::ST_OK;
            end
        endcase
        if (!i_cmd.exec) begin
            ram_we = 1'b0;
            ram_re = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= deq_pkg::t_op'(i_operation);
            r_val <= i_push_value;
        end
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_rd_ok  <= n_rd_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_cnt  <= '0;
        end else if (i_cmd.exec) begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_cnt  <= n_cnt;
        end
    end

    deq_ram #(
        .WIDTH (WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_val),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_read_value = r_rd_ok ? ram_rdata : '0;
    assign o_status     = r_status;
    assign o_count      = r_cnt;

endmodule
`default_nettype wire

// ===== rtl/double_ended_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue
// A request word taken by the sequencer passes through the execute step and
// then the respond step, with its result word on the output ports, marked by
// o_valid; a new word can be captured in that respond step. The slot RAM,
// single-port-per-direction, and its registered read set both steps. Reset
// (synchronous, active low) empties the queue and returns the sequencer to
// idle; slot contents are not cleared. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module double_ended_queue #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic [2:0]                 i_operation,
    input  wire logic [WIDTH-1:0]           i_push_value,
    output logic                            o_valid,
    output logic      [WIDTH-1:0]           o_read_value,
    output logic      [1:0]                 o_status,
    output logic      [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    // The controller walks each request word through capture, execute and
    // respond. Busy is high only in the execute cycle, so a new word can be
    // captured in the same cycle as the previous result word is presented.
    deq_pkg::t_cmd cmd;

    deq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_cmd   (cmd)
    );

    // The datapath holds the ring pointers, the element count and the slot
    // RAM. In execute it sets the status; an accepted request writes or reads a
    // slot, and a push or pop moves the pointers. Read data is ready at respond.
    deq_dp #(
        .DEPTH (DEPTH),
        .WIDTH (WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_operation  (i_operation),
        .i_push_value (i_push_value),
        .o_read_value (o_read_value),
        .o_status     (o_status),
        .o_count      (o_count)
    );

    assign busy    = cmd.exec;
    assign o_valid = cmd.respond;

    // A result word always follows an execute cycle.
    a_valid_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result word without a preceding execute cycle");

    // Execute lasts exactly one cycle and is followed by a result word.
    a_exec_then_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> (o_valid && !busy))
        else $error("execute not followed by a result word");

    // The element count never exceeds the queue depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_count <= CNT_W'(DEPTH)))
        else $error("element count beyond queue depth");

    // A refused request reads nothing.
    a_refused_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != deq_pkg::ST_OK)) |-> (o_read_value == '0))
        else $error("nonzero read value on an empty or full status");

endmodule
`default_nettype wire
